@@ rtl/ultrasonic_range_speed_meter_defines.svh @@
// Assertion macros for the ultrasonic range and speed meter.
`ifndef ULTRASONIC_RANGE_SPEED_METER_DEFINES_SVH
`define ULTRASONIC_RANGE_SPEED_METER_DEFINES_SVH

`ifndef SYNTH
// same-cycle implication, sampled on clk, off during reset
`define URSM_ASSERT_IMPLY(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("ultrasonic meter: same-cycle check failed");
// next-cycle implication, sampled on clk, off during reset
`define URSM_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("ultrasonic meter: next-cycle check failed");
`else
`define URSM_ASSERT_IMPLY(label, ante, cons)
`define URSM_ASSERT_NEXT(label, ante, cons)
`endif

`endif

@@ rtl/urs_pkg.sv @@
// Shared types and constants of the ultrasonic range and speed meter.
`default_nettype none

package urs_pkg;

    // fixed field widths
    localparam int FIELD_W    = 24;
    localparam int PROD_W     = 48;
    localparam int DIV_CNT_W  = $clog2(PROD_W);
    localparam int OUT_DATA_W = 1 + 3 * FIELD_W;
    localparam int TDATA_W    = ((OUT_DATA_W + 7) / 8) * 8;

    localparam logic [FIELD_W-1:0] MASK24      = 24'hFFFFFF;
    localparam logic [FIELD_W-1:0] SPEED_SCALE = 24'd10000000;

    // register reset values
    localparam logic [9:0]  TRIGGER_TICKS_RST = 10'd10;
    localparam logic [23:0] IDLE_TICKS_RST    = 24'd500000;
    localparam logic [7:0]  TICKS_PER_CM_RST  = 8'd58;

    // register indexes (word address)
    localparam logic [1:0] REG_TRIGGER_TICKS = 2'd0;
    localparam logic [1:0] REG_IDLE_TICKS    = 2'd1;
    localparam logic [1:0] REG_TICKS_PER_CM  = 2'd2;

    // controller to datapath
    typedef struct packed {
        logic step;          // input transaction accepted this cycle
        logic div_start;     // launch the divider
        logic div_sel_speed; // 0: distance division, 1: speed division
        logic dist_load;     // capture distance from quotient
        logic diff_load;     // capture |distance - previous|
        logic mul_load;      // capture diff * 10^7
        logic finish;        // write the measurement result
    } urs_cmd_t;

    // datapath to controller
    typedef struct packed {
        logic fall;      // current input tick ends an echo
        logic div_busy;
        logic div_done;
        logic res_free;  // result buffer can take a result this cycle
    } urs_status_t;

endpackage

`default_nettype wire

@@ rtl/urs_div.sv @@
// Restoring divider, one quotient bit per cycle.
`default_nettype none

module urs_div
    import urs_pkg::*;
#(
    parameter int DEN_W = 24
)
(
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              start,
    input  wire logic [PROD_W-1:0] num,
    input  wire logic [DEN_W-1:0]  den,
    output logic      [PROD_W-1:0] quo,
    output logic                   busy,
    output logic                   done
);

    logic                 busy_reg;
    logic                 done_reg;
    logic [DIV_CNT_W-1:0] cnt_reg;
    logic [PROD_W-1:0]    q_reg;
    logic [DEN_W-1:0]     rem_reg;
    logic [DEN_W-1:0]     den_reg;

    logic [DEN_W:0]       rem_sh;
    logic [DEN_W:0]       rem_sub;
    logic                 ge;
    logic                 last;

    // one shift-subtract step
    always_comb
    begin
        rem_sh  = {rem_reg, q_reg[PROD_W-1]};
        ge      = (rem_sh >= {1'b0, den_reg});
        rem_sub = rem_sh - {1'b0, den_reg};
        last    = (cnt_reg == DIV_CNT_W'(PROD_W - 1));
    end

    // control
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= busy_reg && last;
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
            end
            else if (busy_reg)
            begin
                if (last)
                    busy_reg <= 1'b0;
                cnt_reg <= cnt_reg + 1'b1;
            end
        end
    end

    // quotient and remainder
    always_ff @(posedge clk)
    begin
        if (start)
        begin
            q_reg   <= num;
            rem_reg <= '0;
            den_reg <= den;
        end
        else if (busy_reg)
        begin
            q_reg   <= {q_reg[PROD_W-2:0], ge};
            rem_reg <= ge ? rem_sub[DEN_W-1:0] : rem_sh[DEN_W-1:0];
        end
    end

    assign quo  = q_reg;
    assign busy = busy_reg;
    assign done = done_reg;

endmodule

`default_nettype wire

@@ rtl/urs_ctrl.sv @@
// Controller: tick acceptance and measurement sequencing.
`default_nettype none

module urs_ctrl
    import urs_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire urs_status_t status,
    output urs_cmd_t         cmd
);

    typedef enum logic [2:0] {
        ST_READY,
        ST_DIST_GO,
        ST_DIST_WAIT,
        ST_DIFF,
        ST_MUL,
        ST_SPD_GO,
        ST_SPD_WAIT
    } state_t;

    state_t state_reg;
    state_t state_next;
    logic   accept;

    // next state and commands
    always_comb
    begin
        s_tready   = (state_reg == ST_READY) && status.res_free;
        accept     = s_tvalid && s_tready;
        state_next = state_reg;
        cmd        = '0;
        cmd.step   = accept;
        case (state_reg)
            ST_READY:
            begin
                if (accept && status.fall)
                    state_next = ST_DIST_GO;
            end
            ST_DIST_GO:
            begin
                cmd.div_start = 1'b1;
                state_next    = ST_DIST_WAIT;
            end
            ST_DIST_WAIT:
            begin
                if (status.div_done)
                begin
                    cmd.dist_load = 1'b1;
                    state_next    = ST_DIFF;
                end
            end
            ST_DIFF:
            begin
                cmd.diff_load = 1'b1;
                state_next    = ST_MUL;
            end
            ST_MUL:
            begin
                cmd.mul_load = 1'b1;
                state_next   = ST_SPD_GO;
            end
            ST_SPD_GO:
            begin
                cmd.div_start     = 1'b1;
                cmd.div_sel_speed = 1'b1;
                state_next        = ST_SPD_WAIT;
            end
            ST_SPD_WAIT:
            begin
                cmd.div_sel_speed = 1'b1;
                if (status.div_done)
                begin
                    cmd.finish = 1'b1;
                    state_next = ST_READY;
                end
            end
            default:
            begin
                state_next = ST_READY;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= ST_READY;
        else
            state_reg <= state_next;
    end

endmodule

`default_nettype wire

@@ rtl/urs_datapath.sv @@
// Datapath: tick phases, echo timing, distance and speed, result buffering.
`default_nettype none

module urs_datapath
    import urs_pkg::*;
#(
    parameter int TIMER_BITS = 24
)
(
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire urs_cmd_t              cmd,
    input  wire logic                  echo,
    input  wire logic [9:0]            trigger_ticks,
    input  wire logic [23:0]           idle_ticks,
    input  wire logic [7:0]            ticks_per_cm,
    input  wire logic                  m_tready,
    output logic                       m_tvalid,
    output logic [OUT_DATA_W-1:0]      m_data,
    output logic                       m_flag,
    output urs_status_t                status
);

    localparam int T  = TIMER_BITS;
    localparam int CW = ((T > FIELD_W) ? T : FIELD_W) + 1;
    localparam logic [T-1:0] TMAX = {T{1'b1}};

    typedef enum logic [1:0] {
        PH_IDLE,
        PH_TRIG,
        PH_WAIT,
        PH_COUNT
    } phase_t;

    // sequencing state
    phase_t              phase_reg,        phase_next;
    logic [T-1:0]        phase_timer_reg,  phase_timer_next;
    logic [T-1:0]        echo_width_reg,   echo_width_next;
    logic [T-1:0]        interval_reg,     interval_next;
    logic [T-1:0]        last_int_reg,     last_int_next;
    logic [FIELD_W-1:0]  prev_dist_reg,    prev_dist_next;
    logic                have_prev_reg,    have_prev_next;
    logic                res_full_reg,     res_full_next;
    logic                out_valid_reg,    out_valid_next;

    // measurement payload
    logic [T-1:0]        ew_hold_reg;
    logic [FIELD_W-1:0]  dist_reg;
    logic [FIELD_W-1:0]  diff_reg;
    logic [PROD_W-1:0]   prod_reg;
    logic                res_trig_reg,     res_trig_next;
    logic                res_valid_reg,    res_valid_next;
    logic [FIELD_W-1:0]  res_dist_reg,     res_dist_next;
    logic [FIELD_W-1:0]  res_speed_reg,    res_speed_next;
    logic [FIELD_W-1:0]  res_ivl_reg,      res_ivl_next;
    logic [OUT_DATA_W-1:0] out_data_reg;
    logic                out_flag_reg;

    logic [CW-1:0]       pt_plus;
    logic [CW-1:0]       lim_ext;
    logic [23:0]         idle_lim;
    logic [9:0]          trig_lim;
    logic                ph_done;
    logic [T-1:0]        it_base;
    logic [CW-1:0]       li_ext;
    logic [FIELD_W-1:0]  li_sat;
    logic [FIELD_W-1:0]  q_sat;
    logic                move;
    logic                fall;

    logic [PROD_W-1:0]   div_num;
    logic [T-1:0]        div_den;
    logic [PROD_W-1:0]   div_quo;
    logic                div_busy;
    logic                div_done;

    // shared divider for distance and speed
    assign div_num = cmd.div_sel_speed ? prod_reg : PROD_W'(ew_hold_reg);
    assign div_den = cmd.div_sel_speed ? last_int_reg : T'(ticks_per_cm);

    urs_div #(
        .DEN_W (T)
    ) u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .start (cmd.div_start),
        .num   (div_num),
        .den   (div_den),
        .quo   (div_quo),
        .busy  (div_busy),
        .done  (div_done)
    );

    // phase timer limit and saturations
    always_comb
    begin
        idle_lim = (idle_ticks == 24'd0) ? 24'd1 : idle_ticks;
        trig_lim = (trigger_ticks == 10'd0) ? 10'd1 : trigger_ticks;
        lim_ext  = (phase_reg == PH_TRIG) ? CW'(trig_lim) : CW'(idle_lim);
        pt_plus  = CW'(phase_timer_reg) + 1'b1;
        ph_done  = (pt_plus >= lim_ext) || (phase_timer_reg == TMAX);
        li_ext   = CW'(last_int_reg);
        li_sat   = (li_ext > CW'(MASK24)) ? MASK24 : li_ext[FIELD_W-1:0];
        q_sat    = (|div_quo[PROD_W-1:FIELD_W]) ? MASK24 : div_quo[FIELD_W-1:0];
        fall     = (phase_reg == PH_COUNT) && !echo;
        move     = res_full_reg && (!out_valid_reg || m_tready);
    end

    // tick step, measurement finish and result buffer
    always_comb
    begin
        phase_next       = phase_reg;
        phase_timer_next = phase_timer_reg;
        echo_width_next  = echo_width_reg;
        interval_next    = interval_reg;
        last_int_next    = last_int_reg;
        prev_dist_next   = prev_dist_reg;
        have_prev_next   = have_prev_reg;
        res_trig_next    = res_trig_reg;
        res_valid_next   = res_valid_reg;
        res_dist_next    = res_dist_reg;
        res_speed_next   = res_speed_reg;
        res_ivl_next     = res_ivl_reg;
        res_full_next    = res_full_reg && !move;
        it_base          = interval_reg;

        if (cmd.step)
        begin
            res_trig_next = 1'b0;
            case (phase_reg)
                PH_IDLE:
                begin
                    if (ph_done)
                    begin
                        phase_next       = PH_TRIG;
                        phase_timer_next = '0;
                    end
                    else
                        phase_timer_next = phase_timer_reg + 1'b1;
                end
                PH_TRIG:
                begin
                    res_trig_next = 1'b1;
                    // trigger start: latch and restart the interval timer
                    if (phase_timer_reg == '0)
                    begin
                        last_int_next = interval_reg;
                        it_base       = '0;
                    end
                    if (ph_done)
                    begin
                        phase_next       = PH_WAIT;
                        phase_timer_next = '0;
                    end
                    else
                        phase_timer_next = phase_timer_reg + 1'b1;
                end
                PH_WAIT:
                begin
                    if (echo)
                    begin
                        echo_width_next = T'(1);
                        phase_next      = PH_COUNT;
                    end
                end
                default:
                begin
                    if (echo)
                        echo_width_next = (echo_width_reg == TMAX) ? TMAX
                                                                   : echo_width_reg + 1'b1;
                    else
                    begin
                        echo_width_next  = '0;
                        phase_next       = PH_IDLE;
                        phase_timer_next = '0;
                    end
                end
            endcase
            interval_next = (it_base == TMAX) ? TMAX : it_base + 1'b1;

            // ticks that end no echo give their result at once
            if (!fall)
            begin
                res_valid_next = 1'b0;
                res_dist_next  = '0;
                res_speed_next = '0;
                res_ivl_next   = '0;
                res_full_next  = 1'b1;
            end
        end

        if (cmd.finish)
        begin
            res_trig_next  = 1'b0;
            res_valid_next = 1'b1;
            res_dist_next  = dist_reg;
            if (!have_prev_reg || (diff_reg == '0))
                res_speed_next = '0;
            else if (last_int_reg == '0)
                res_speed_next = MASK24;
            else
                res_speed_next = q_sat;
            res_ivl_next   = have_prev_reg ? li_sat : '0;
            prev_dist_next = dist_reg;
            have_prev_next = 1'b1;
            res_full_next  = 1'b1;
        end

        if (move)
            out_valid_next = 1'b1;
        else if (m_tready)
            out_valid_next = 1'b0;
        else
            out_valid_next = out_valid_reg;
    end

    // control and model state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg       <= PH_IDLE;
            phase_timer_reg <= '0;
            echo_width_reg  <= '0;
            interval_reg    <= '0;
            last_int_reg    <= '0;
            prev_dist_reg   <= '0;
            have_prev_reg   <= 1'b0;
            res_full_reg    <= 1'b0;
            out_valid_reg   <= 1'b0;
        end
        else
        begin
            phase_reg       <= phase_next;
            phase_timer_reg <= phase_timer_next;
            echo_width_reg  <= echo_width_next;
            interval_reg    <= interval_next;
            last_int_reg    <= last_int_next;
            prev_dist_reg   <= prev_dist_next;
            have_prev_reg   <= have_prev_next;
            res_full_reg    <= res_full_next;
            out_valid_reg   <= out_valid_next;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (cmd.step && fall)
            ew_hold_reg <= echo_width_reg;
        if (cmd.dist_load)
            dist_reg <= (ticks_per_cm == 8'd0) ? MASK24 : q_sat;
        if (cmd.diff_load)
            diff_reg <= (dist_reg > prev_dist_reg) ? dist_reg - prev_dist_reg
                                                   : prev_dist_reg - dist_reg;
        if (cmd.mul_load)
            prod_reg <= PROD_W'(diff_reg) * PROD_W'(SPEED_SCALE);
        res_trig_reg  <= res_trig_next;
        res_valid_reg <= res_valid_next;
        res_dist_reg  <= res_dist_next;
        res_speed_reg <= res_speed_next;
        res_ivl_reg   <= res_ivl_next;
        if (move)
        begin
            out_data_reg <= {res_ivl_reg, res_speed_reg, res_dist_reg, res_trig_reg};
            out_flag_reg <= res_valid_reg;
        end
    end

    assign m_tvalid        = out_valid_reg;
    assign m_data          = out_data_reg;
    assign m_flag          = out_flag_reg;
    assign status.fall     = fall;
    assign status.div_busy = div_busy;
    assign status.div_done = div_done;
    assign status.res_free = !res_full_reg || move;

endmodule

`default_nettype wire

@@ rtl/ultrasonic_range_speed_meter.sv @@
// Top level: ultrasonic echo ranging with distance and speed per echo.
// A tick that ends no echo goes through the result buffer and output register to m_*;
// one tick per cycle while the result buffer is free. An echo-ending tick runs two
// 48-step divisions in one shared shift-subtract divider; no tick taken meanwhile.
// Reset (rst_n, async, active low) clears phase, timers, history and both output stages.
`default_nettype none
`include "ultrasonic_range_speed_meter_defines.svh"

module ultrasonic_range_speed_meter
    import urs_pkg::*;
#(
    parameter int TIMER_BITS = 24
)
(
    input  wire logic               clk,
    input  wire logic               rst_n,
    // input tick stream
    input  wire logic               s_tvalid,
    output logic                    s_tready,
    input  wire logic [7:0]         s_tdata,  // [0] echo_level, [7:1] zero
    // result stream
    output logic                    m_tvalid,
    input  wire logic               m_tready,
    output logic [TDATA_W-1:0]      m_tdata,  // [0] trigger_level, [24:1] distance_cm,
                                              // [48:25] speed_mm_s, [72:49] interval_ticks
    output logic [0:0]              m_tuser,  // [0] result_valid
    // configuration port
    input  wire logic               psel,
    input  wire logic               penable,
    input  wire logic               pwrite,
    input  wire logic [3:0]         paddr,
    input  wire logic [31:0]        pwdata,
    output logic [31:0]             prdata,
    output logic                    pready
);

    logic [9:0]            trigger_ticks_reg;
    logic [23:0]           idle_ticks_reg;
    logic [7:0]            ticks_per_cm_reg;
    logic                  cfg_write;
    urs_cmd_t              cmd;
    urs_status_t           status;
    logic [OUT_DATA_W-1:0] m_data;
    logic                  m_flag;

    // configuration registers
    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            trigger_ticks_reg <= TRIGGER_TICKS_RST;
            idle_ticks_reg    <= IDLE_TICKS_RST;
            ticks_per_cm_reg  <= TICKS_PER_CM_RST;
        end
        else if (cfg_write)
        begin
            case (paddr[3:2])
                REG_TRIGGER_TICKS: trigger_ticks_reg <= pwdata[9:0];
                REG_IDLE_TICKS:    idle_ticks_reg    <= pwdata[23:0];
                REG_TICKS_PER_CM:  ticks_per_cm_reg  <= pwdata[7:0];
                default:           ;
            endcase
        end
    end

    // register readback
    always_comb
    begin
        case (paddr[3:2])
            REG_TRIGGER_TICKS: prdata = {22'd0, trigger_ticks_reg};
            REG_IDLE_TICKS:    prdata = {8'd0, idle_ticks_reg};
            REG_TICKS_PER_CM:  prdata = {24'd0, ticks_per_cm_reg};
            default:           prdata = '0;
        endcase
    end

    urs_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .status   (status),
        .cmd      (cmd)
    );

    urs_datapath #(
        .TIMER_BITS (TIMER_BITS)
    ) u_datapath (
        .clk           (clk),
        .rst_n         (rst_n),
        .cmd           (cmd),
        .echo          (s_tdata[0]),
        .trigger_ticks (trigger_ticks_reg),
        .idle_ticks    (idle_ticks_reg),
        .ticks_per_cm  (ticks_per_cm_reg),
        .m_tready      (m_tready),
        .m_tvalid      (m_tvalid),
        .m_data        (m_data),
        .m_flag        (m_flag),
        .status        (status)
    );

    assign m_tdata = {{(TDATA_W - OUT_DATA_W){1'b0}}, m_data};
    assign m_tuser = m_flag;

    // a tick without a measurement carries zero result fields
    `URSM_ASSERT_IMPLY(a_no_meas_zero, m_tvalid && !m_tuser[0], m_tdata[OUT_DATA_W-1:1] == '0)
    // the trigger is never driven on the tick that ends an echo
    `URSM_ASSERT_IMPLY(a_trig_not_meas, m_tvalid && m_tuser[0], !m_tdata[0])
    // an echo-ending tick blocks further ticks while it is measured
    `URSM_ASSERT_NEXT(a_fall_blocks, s_tvalid && s_tready && status.fall, !s_tready)
    // the divider is only launched when idle
    `URSM_ASSERT_IMPLY(a_div_idle_start, cmd.div_start, !status.div_busy)

endmodule

`default_nettype wire

@@ verif/ultrasonic_range_speed_meter_test.sv @@
`timescale 1ns / 100ps
// Testbench for the ultrasonic range and speed meter: tick driver, predictor and result checker.
module ultrasonic_range_speed_meter_test;
    import urs_pkg::*;

    localparam int TIMER_W = 24;
    localparam longint unsigned TIMER_MAX = (64'd1 << TIMER_W) - 1;
    localparam int STALL_LIMIT = 4000;    // cycles with no transaction before giving up
    localparam int DRAIN_CYCLES = 200;
    localparam logic [1:0] REG_SPARE = 2'd3;

    typedef enum logic [1:0] {
        PH_LOW,
        PH_PULSE,
        PH_LISTEN,
        PH_MEASURE
    } ranging_phase_t;

    typedef struct packed {
        logic        trig;
        logic        valid;
        logic [23:0] distance;
        logic [23:0] speed;
        logic [23:0] interval;
    } meter_result_t;

    logic               clk = 1'b0;
    logic               rst_n = 1'b0;
    logic               s_tvalid = 1'b0;
    logic               s_tready;
    logic [7:0]         s_tdata = 8'd0;
    logic               m_tvalid;
    logic               m_tready = 1'b0;
    logic [TDATA_W-1:0] m_tdata;
    logic [0:0]         m_tuser;
    logic               psel = 1'b0;
    logic               penable = 1'b0;
    logic               pwrite = 1'b0;
    logic [3:0]         paddr = 4'd0;
    logic [31:0]        pwdata = 32'd0;
    logic [31:0]        prdata;
    logic               pready;

    // pending echo samples; the front is the one on s_tdata
    bit            echo_ticks[$];
    meter_result_t expected_results[$];

    // predictor copy of registers and state
    logic [9:0]        cfg_trigger = TRIGGER_TICKS_RST;
    logic [23:0]       cfg_idle = IDLE_TICKS_RST;
    logic [7:0]        cfg_tpc = TICKS_PER_CM_RST;
    ranging_phase_t    ranging_phase = PH_LOW;
    longint unsigned   phase_timer = 0;
    longint unsigned   echo_count = 0;
    longint unsigned   interval_timer = 0;
    longint unsigned   prev_interval = 0;
    longint unsigned   prev_distance = 0;
    bit                have_prev = 1'b0;

    // handshake pacing
    bit src_taken = 1'b0;
    int src_gap = 0;
    int src_idle_pct = 0;
    int sink_gap = 0;
    int sink_idle_pct = 0;
    int sink_hold_req = 0;
    int sink_hold_left = 0;
    int idle_cycles = 0;
    int mismatches = 0;

    ultrasonic_range_speed_meter #(
        .TIMER_BITS(TIMER_W)
    ) uut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready)
    );

    initial
    begin
        forever #5 clk = ~clk;
    end

    function automatic longint unsigned sat_inc(input longint unsigned v);
        return (v >= TIMER_MAX) ? TIMER_MAX : v + 1;
    endfunction

    function automatic longint unsigned sat24(input longint unsigned v);
        return (v > MASK24) ? MASK24 : v;
    endfunction

    // advance the phase timer; 1 when a phase of 'limit' ticks is over
    function automatic bit phase_over(input longint unsigned limit);
        longint unsigned lim;
        lim = (limit == 0) ? 1 : limit;
        if (phase_timer + 1 >= lim || phase_timer >= TIMER_MAX)
            return 1'b1;
        phase_timer = sat_inc(phase_timer);
        return 1'b0;
    endfunction

    // one microsecond tick of the ranging sequencer
    function automatic meter_result_t predict_tick(input bit echo);
        meter_result_t   r;
        longint unsigned dist_cm;
        longint unsigned diff;
        longint unsigned spd;
        r = '0;
        case (ranging_phase)
            PH_LOW:
            begin
                if (phase_over(cfg_idle))
                begin
                    ranging_phase = PH_PULSE;
                    phase_timer = 0;
                end
            end
            PH_PULSE:
            begin
                r.trig = 1'b1;
                // trigger start: latch the interval and restart it
                if (phase_timer == 0)
                begin
                    prev_interval = interval_timer;
                    interval_timer = 0;
                end
                if (phase_over(cfg_trigger))
                begin
                    ranging_phase = PH_LISTEN;
                    phase_timer = 0;
                end
            end
            PH_LISTEN:
            begin
                if (echo)
                begin
                    echo_count = 1;
                    ranging_phase = PH_MEASURE;
                end
            end
            default:
            begin
                if (echo)
                    echo_count = sat_inc(echo_count);
                else
                begin
                    // falling edge: report distance and speed
                    r.valid = 1'b1;
                    dist_cm = (cfg_tpc == 0) ? MASK24 : sat24(echo_count / cfg_tpc);
                    r.distance = 24'(dist_cm);
                    if (have_prev)
                    begin
                        diff = (dist_cm > prev_distance) ? dist_cm - prev_distance
                                                         : prev_distance - dist_cm;
                        if (diff == 0)
                            spd = 0;
                        else if (prev_interval == 0)
                            spd = MASK24;
                        else
                            spd = sat24((diff * SPEED_SCALE) / prev_interval);
                        r.speed = 24'(spd);
                        r.interval = 24'(sat24(prev_interval));
                    end
                    prev_distance = dist_cm;
                    have_prev = 1'b1;
                    echo_count = 0;
                    ranging_phase = PH_LOW;
                    phase_timer = 0;
                end
            end
        endcase
        interval_timer = sat_inc(interval_timer);
        return r;
    endfunction

    // tick driver: holds an offered transaction until it is taken
    always @(negedge clk)
    begin
        bit         offer;
        logic [7:0] data;
        offer = 1'b0;
        data = s_tdata;
        if (!rst_n)
            offer = 1'b0;
        else if (s_tvalid && !src_taken)
            offer = 1'b1;
        else if (src_gap > 0)
            src_gap--;
        else if (echo_ticks.size() > 0)
        begin
            if (src_idle_pct > 0 && $urandom_range(99) < src_idle_pct)
                src_gap = $urandom_range(6);
            else
            begin
                offer = 1'b1;
                data = {7'd0, echo_ticks[0]};
            end
        end
        s_tvalid <= offer;
        s_tdata <= data;
    end

    // result receiver with random stalls and an optional long hold-off
    always @(negedge clk)
    begin
        bit ready;
        ready = 1'b0;
        if (sink_hold_req > 0)
        begin
            sink_hold_left = sink_hold_req;
            sink_hold_req = 0;
        end
        if (!rst_n)
            ready = 1'b0;
        else if (sink_hold_left > 0)
            sink_hold_left--;
        else if (sink_gap > 0)
            sink_gap--;
        else if (sink_idle_pct > 0 && $urandom_range(99) < sink_idle_pct)
            sink_gap = $urandom_range(6);
        else
            ready = 1'b1;
        m_tready <= ready;
    end

    // monitor: register port, result check, prediction, watchdog
    always @(posedge clk)
    begin
        meter_result_t got;
        meter_result_t want;
        logic [31:0]   want_reg;
        bit            moved;
        moved = 1'b0;
        src_taken = s_tvalid && s_tready;
        if (rst_n)
        begin
            if (psel && penable && pready)
            begin
                if (pwrite)
                begin
                    case (paddr[3:2])
                        REG_TRIGGER_TICKS: cfg_trigger = pwdata[9:0];
                        REG_IDLE_TICKS:    cfg_idle = pwdata[23:0];
                        REG_TICKS_PER_CM:  cfg_tpc = pwdata[7:0];
                        default: ;
                    endcase
                end
                else
                begin
                    case (paddr[3:2])
                        REG_TRIGGER_TICKS: want_reg = {22'd0, cfg_trigger};
                        REG_IDLE_TICKS:    want_reg = {8'd0, cfg_idle};
                        REG_TICKS_PER_CM:  want_reg = {24'd0, cfg_tpc};
                        default:           want_reg = 32'd0;
                    endcase
                    if (prdata !== want_reg)
                    begin
                        mismatches++;
                        $display("%0t: register %0d read, expected %0h, got %0h",
                                 $time, paddr[3:2], want_reg, prdata);
                    end
                end
            end

            if (m_tvalid && m_tready)
            begin
                moved = 1'b1;
                got.trig = m_tdata[0];
                got.valid = m_tuser[0];
                got.distance = m_tdata[24:1];
                got.speed = m_tdata[48:25];
                got.interval = m_tdata[72:49];
                if (expected_results.size() == 0)
                begin
                    mismatches++;
                    $display("%0t: unexpected result, expected none, got %h",
                             $time, got);
                end
                else
                begin
                    want = expected_results.pop_front();
                    if (got !== want)
                    begin
                        mismatches++;
                        $display({"%0t: result mismatch, expected trig %0d valid %0d ",
                                  "dist %0d speed %0d ivl %0d, got trig %0d valid %0d ",
                                  "dist %0d speed %0d ivl %0d"},
                                 $time, want.trig, want.valid, want.distance,
                                 want.speed, want.interval, got.trig, got.valid,
                                 got.distance, got.speed, got.interval);
                    end
                end
            end

            if (src_taken)
            begin
                moved = 1'b1;
                expected_results.push_back(predict_tick(s_tdata[0]));
                void'(echo_ticks.pop_front());
            end

            idle_cycles = moved ? 0 : idle_cycles + 1;
            if (idle_cycles >= STALL_LIMIT)
            begin
                $display("Verification failed");
                $finish;
            end
        end
    end

    task automatic reg_write(input logic [1:0] idx, input logic [31:0] value);
        @(negedge clk);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= {idx, 2'b00};
        pwdata <= value;
        @(negedge clk);
        penable <= 1'b1;
        @(negedge clk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
    endtask

    task automatic reg_read(input logic [1:0] idx);
        @(negedge clk);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b0;
        paddr <= {idx, 2'b00};
        @(negedge clk);
        penable <= 1'b1;
        @(negedge clk);
        psel <= 1'b0;
        penable <= 1'b0;
    endtask

    task automatic read_all_regs();
        reg_read(REG_TRIGGER_TICKS);
        reg_read(REG_IDLE_TICKS);
        reg_read(REG_TICKS_PER_CM);
    endtask

    task automatic program_meter(input logic [31:0] trig, input logic [31:0] idle,
                                 input logic [31:0] tpc);
        reg_write(REG_TRIGGER_TICKS, trig);
        reg_write(REG_IDLE_TICKS, idle);
        reg_write(REG_TICKS_PER_CM, tpc);
        read_all_regs();
    endtask

    task automatic push_run(input bit level, input int count);
        repeat (count) echo_ticks.push_back(level);
    endtask

    // sender pause: every tick taken and every result back
    task automatic wait_idle();
        @(negedge clk);
        while (echo_ticks.size() != 0 || expected_results.size() != 0)
            @(negedge clk);
    endtask

    // mostly whole ranging cycles with random widths, some random noise
    task automatic run_random(input int n_ticks, input int src_pct, input int sink_pct);
        int pushed;
        int low_len;
        int high_len;
        int pick;
        src_idle_pct = src_pct;
        sink_idle_pct = sink_pct;
        pushed = 0;
        while (pushed < n_ticks)
        begin
            pick = $urandom_range(99);
            if (pick < 85)
            begin
                low_len = cfg_idle + cfg_trigger + $urandom_range(1, 6);
                pick = $urandom_range(99);
                if (pick < 75)
                    high_len = $urandom_range(1, 40);
                else if (pick < 95)
                    high_len = $urandom_range(41, 120);
                else
                    high_len = $urandom_range(121, 300);
                push_run(1'b0, low_len);
                push_run(1'b1, high_len);
                pushed += low_len + high_len;
            end
            else
            begin
                repeat ($urandom_range(1, 8))
                begin
                    echo_ticks.push_back(1'($urandom_range(1)));
                    pushed++;
                end
            end
        end
        wait_idle();
    endtask

    // stimulus sequence
    initial
    begin
        int k;
        int src_pct;
        int sink_pct;
        repeat (10) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // reset values, then a couple of ticks deep in the default idle time
        read_all_regs();
        src_idle_pct = 20;
        sink_idle_pct = 20;
        push_run(1'b0, 2);
        wait_idle();

        // shortest phases, upper bits of the write data must be dropped;
        // echo high in the idle and trigger ticks is ignored
        program_meter(32'hFFFF_FC01, 32'hAB00_0001, 32'h1234_5601);
        push_run(1'b1, 2);
        push_run(1'b0, 1);
        push_run(1'b1, 2);
        push_run(1'b0, 1);
        push_run(1'b0, 3);
        push_run(1'b1, 4);
        push_run(1'b0, 1);
        wait_idle();

        // zero registers act as 1, zero divisor saturates distance;
        // second equal distance gives zero speed; spare index is ignored
        program_meter(32'd0, 32'd0, 32'd0);
        reg_write(REG_SPARE, 32'h0000_0007);
        repeat (2)
        begin
            push_run(1'b0, 3);
            push_run(1'b1, 1);
            push_run(1'b0, 1);
        end
        wait_idle();

        // largest register values, a few ticks only
        program_meter(32'h0000_03FF, 32'h00FF_FFFF, 32'h0000_00FF);
        push_run(1'b1, 3);
        push_run(1'b0, 3);
        wait_idle();

        // random phases, the last one without idling
        for (k = 0; k < 6; k++)
        begin
            program_meter((k == 3) ? $urandom_range(0, 12) : $urandom_range(1, 3),
                          $urandom_range(0, 6),
                          ($urandom_range(2) == 0) ? $urandom_range(0, 255)
                                                   : $urandom_range(1, 12));
            src_pct = (k == 5) ? 0 : $urandom_range(0, 2) * 20;
            sink_pct = (k == 5) ? 0 : $urandom_range(0, 2) * 20;
            if (k == 2)
                sink_hold_req = 400;
            run_random(60, src_pct, sink_pct);
        end

        repeat (DRAIN_CYCLES) @(posedge clk);
        if (mismatches == 0 && expected_results.size() == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

endmodule
